// ===== sv/horner_polynomial_evaluator_macros.svh =====
// Assertion macros for the Horner polynomial evaluator.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef HORNER_POLYNOMIAL_EVALUATOR_MACROS_SVH
`define HORNER_POLYNOMIAL_EVALUATOR_MACROS_SVH

`ifndef SYNTH
`define HPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HPE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define HPE_ASSERT(lbl, prop, msg)
`define HPE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/hpe_pkg.sv =====
// Shared constants and types for the Horner polynomial evaluator.
// No dependencies.
package hpe_pkg;

  localparam int unsigned MAX_DEGREE = 15;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned STORE_DEPTH = MAX_DEGREE + 1;
  localparam int unsigned IDX_W      = $clog2(STORE_DEPTH);

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned SUM_W   = PROD_W - FRAC_BITS + 1;
  localparam int unsigned DEG_W   = 4;
  localparam int unsigned CIDX_W  = 4;
  localparam int unsigned IN_W    = CIDX_W + 2 * DATA_W;
  localparam int unsigned IN_TDATA_W = ((IN_W + 7) / 8) * 8;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [IDX_W-1:0]         idx_t;

endpackage

// ===== sv/horner_polynomial_evaluator.sv =====
// Horner polynomial evaluator: 32-bit signed Q16.16, 16-entry coefficient store.
// Depends on hpe_pkg and horner_polynomial_evaluator_macros.svh.
// A write beat stores its coefficient when accepted; an evaluate beat loads the top coefficient,
// then takes one multiply step and one add-and-saturate step per lower coefficient (d = degree),
// then a finish step that waits on output back-pressure. No new beat is taken until it is done.
// Reset clears degree and all coefficients at once; the block is ready after reset.
`include "horner_polynomial_evaluator_macros.svh"

module horner_polynomial_evaluator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hpe_pkg::DEG_W-1:0]       cfg_wdata_i,    // degree
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // coeff_index[3:0], coeff_value[35:4], eval_point[67:36], zero pad
  input  logic [hpe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tuser,   // func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [hpe_pkg::DATA_W-1:0]      m_axis_tdata,   // poly_value
  output logic                            m_axis_tuser    // overflow
);
  import hpe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [DEG_W-1:0]       degree_q;
  word_t                  store_q [STORE_DEPTH];
  idx_t                   idx_q, idx_d;
  word_t                  acc_q, acc_d;
  word_t                  x_q, x_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic                   ovf_q, ovf_d;
  logic                   m_valid_q;
  word_t                  m_data_q;
  logic                   m_ovf_q;

  logic [CIDX_W-1:0]      in_idx;
  word_t                  in_coeff;
  word_t                  in_point;
  logic                   in_fire;
  logic                   wr_en;
  idx_t                   top;
  idx_t                   idx_dec;
  logic signed [SUM_W-1:0] sum;
  logic                   sat_hi, sat_lo;
  logic                   out_free;
  logic                   out_load;

  assign in_idx   = s_axis_tdata[CIDX_W-1:0];
  assign in_coeff = s_axis_tdata[CIDX_W +: DATA_W];
  assign in_point = s_axis_tdata[CIDX_W+DATA_W +: DATA_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign wr_en    = in_fire && (s_axis_tuser == FUNC_WRITE)
                    && ({1'b0, in_idx} <= (CIDX_W+1)'(MAX_DEGREE));
  assign top      = ({1'b0, degree_q} > (DEG_W+1)'(MAX_DEGREE)) ? IDX_W'(MAX_DEGREE)
                                                                : IDX_W'(degree_q);
  assign idx_dec  = idx_q - 1'b1;
  assign sum      = SUM_W'($signed(prod_q[PROD_W-1:FRAC_BITS]))
                    + SUM_W'(store_q[idx_dec]);
  assign sat_hi   = sum > SUM_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
  assign sat_lo   = sum < SUM_W'($signed({1'b1, {(DATA_W-1){1'b0}}}));
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_FIN) && out_free;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    acc_d   = acc_q;
    x_d     = x_q;
    ovf_d   = ovf_q;
    prod_d  = prod_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (s_axis_tuser == FUNC_EVAL)) begin
          idx_d   = top;
          acc_d   = store_q[top];
          x_d     = in_point;
          ovf_d   = 1'b0;
          state_d = (top == '0) ? ST_FIN : ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = acc_q * x_q;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (sat_hi) begin
          acc_d = {1'b0, {(DATA_W-1){1'b1}}};
          ovf_d = 1'b1;
        end else if (sat_lo) begin
          acc_d = {1'b1, {(DATA_W-1){1'b0}}};
          ovf_d = 1'b1;
        end else begin
          acc_d = sum[DATA_W-1:0];
        end
        idx_d   = idx_dec;
        state_d = (idx_dec == '0) ? ST_FIN : ST_MUL;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      degree_q  <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        degree_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        store_q[IDX_W'(in_idx)] <= in_coeff;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    acc_q  <= acc_d;
    x_q    <= x_d;
    ovf_q  <= ovf_d;
    prod_q <= prod_d;
    if (out_load) begin
      m_data_q <= acc_q;
      m_ovf_q  <= ovf_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_ovf_q;

  `HPE_ASSERT(a_eval_starts, (in_fire && (s_axis_tuser == FUNC_EVAL) && (top != '0)) |=> (state_q == ST_MUL), "evaluate beat did not start the multiply loop")
  `HPE_ASSERT(a_result_from_fin, $rose(m_axis_tvalid) |-> ($past(state_q) == ST_FIN), "result beat raised outside the finish step")
  `HPE_ASSERT(a_mul_then_acc, (state_q == ST_MUL) |=> (state_q == ST_ACC), "multiply not followed by accumulate")
  `HPE_ASSERT_ALWAYS(a_acc_idx_nonzero, (state_q == ST_ACC) |-> (idx_q != '0), "accumulate step with coefficient index zero")

endmodule
